FILE: rtl/cba_pkg.sv
// Shared types and codes for the contiguous block allocator.
// Used by cba_cell and contiguous_block_allocator; no dependencies.
package cba_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] region_id;
    logic [15:0] region_size;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] region_start;
    logic [15:0] region_end;
    logic [15:0] free_space;
  } rsp_item_t;

  localparam logic [1:0] OP_FIRST_FIT = 2'd0;
  localparam logic [1:0] OP_BEST_FIT  = 2'd1;
  localparam logic [1:0] OP_FREE      = 2'd2;
  localparam logic [1:0] OP_COMPACT   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXCEEDS   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NO_HOLE   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_FROM_LO,
    CMD_FROM_HI,
    CMD_LOAD,
    CMD_MOVE,
    CMD_KILL,
    CMD_CLEAR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic [15:0] key;
  } cell_ctrl_t;

endpackage

FILE: rtl/cba_cell.sv
// One slot of the region table: valid, id, start and end of a region.
// Loads from either neighbor for insert and remove; depends on cba_pkg.
module cba_cell import cba_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic                 lo_valid,
  input  logic [15:0]          lo_ident,
  input  logic [ADDR_BITS-1:0] lo_first,
  input  logic [ADDR_BITS-1:0] lo_last,
  input  logic                 hi_valid,
  input  logic [15:0]          hi_ident,
  input  logic [ADDR_BITS-1:0] hi_first,
  input  logic [ADDR_BITS-1:0] hi_last,
  input  logic [15:0]          new_ident,
  input  logic [ADDR_BITS-1:0] new_first,
  input  logic [ADDR_BITS-1:0] new_last,
  output logic                 valid,
  output logic [15:0]          ident,
  output logic [ADDR_BITS-1:0] first,
  output logic [ADDR_BITS-1:0] last,
  output logic                 match
);

  assign match = valid && (ident == ctrl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.cmd)
        CMD_FROM_LO: valid <= lo_valid;
        CMD_FROM_HI: valid <= hi_valid;
        CMD_LOAD:    valid <= 1'b1;
        CMD_KILL,
        CMD_CLEAR:   valid <= 1'b0;
        default:     valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_FROM_LO: begin
        ident <= lo_ident;
        first <= lo_first;
        last  <= lo_last;
      end
      CMD_FROM_HI: begin
        ident <= hi_ident;
        first <= hi_first;
        last  <= hi_last;
      end
      CMD_LOAD: begin
        ident <= new_ident;
        first <= new_first;
        last  <= new_last;
      end
      CMD_MOVE: begin
        first <= new_first;
        last  <= new_last;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/contiguous_block_allocator.sv
// Top level of the contiguous block allocator: sequencer and chain of cells.
// Depends on cba_pkg and cba_cell.
//
//   channel | signals                    | payload
//   req     | req_valid, req_ready       | req_item_t
//   rsp     | rsp_valid, rsp_ready       | rsp_item_t
//   cfg     | cfg_valid, cfg_ready       | cfg_data (memory size)
//
// Free requests and those rejected in S_CHECK go straight to S_DONE; compact
// moves each region in S_COMPACT; allocation scans one hole per cycle in S_SCAN,
// then loads a cell in S_INSERT. The block returns to S_IDLE before the next
// accept. Reset is synchronous; the table starts empty with the full space.
// A result waits in the rsp register; the next one stalls in S_DONE behind it.
// cfg is taken only when idle with no result pending.
module contiguous_block_allocator import cba_pkg::*; #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int A  = ADDR_BITS;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_INSERT  = 3'd3;
  localparam logic [2:0] S_COMPACT = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  function automatic logic [15:0] to16(input logic [A-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[15:0];
  endfunction

  function automatic logic [A-1:0] toa(input logic [15:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[A-1:0];
  endfunction

  logic [2:0]    state;
  logic [A-1:0]  total_size;
  logic [A-1:0]  space;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [1:0]    op;
  logic [15:0]   id;
  logic [15:0]   size;
  logic [A-1:0]  prev_last;
  logic [A-1:0]  cursor;
  logic          found;
  logic [IW-1:0] pick;
  logic [A-1:0]  pick_lo;
  logic [A-1:0]  pick_len;
  logic [2:0]    res_status;
  logic [A-1:0]  res_start;
  logic [A-1:0]  res_end;

  logic             v   [MAX_REGIONS];
  logic [15:0]      idt [MAX_REGIONS];
  logic [A-1:0]     fst [MAX_REGIONS];
  logic [A-1:0]     lst [MAX_REGIONS];
  logic             mt  [MAX_REGIONS];
  cell_ctrl_t       ctl [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] vbits;

  logic          any_match;
  logic [IW-1:0] at;
  logic [IW-1:0] kidx;
  logic [A-1:0]  size_a;
  logic [A-1:0]  hi;
  logic [A-1:0]  len;
  logic          fits;
  logic          take;
  logic [A-1:0]  mlen;
  logic [A-1:0]  new_first;
  logic [A-1:0]  new_last;
  logic          cfg_fire;
  logic          free_hit;
  logic [CW-1:0] last_used;

  assign cfg_ready = (state == S_IDLE) && !rsp_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign req_ready = (state == S_IDLE) && !cfg_fire;
  assign kidx      = k[IW-1:0];
  assign size_a    = toa(size);
  assign last_used = count - CW'(1);

  always_comb begin
    any_match = 1'b0;
    at = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      vbits[i] = v[i];
      if (mt[i]) begin
        any_match = 1'b1;
        at = IW'(i);
      end
    end
  end

  assign hi   = (k < count) ? fst[kidx] : total_size;
  assign len  = (hi > prev_last) ? hi - prev_last : '0;
  assign fits = 32'(size) <= 32'(len);
  assign take = fits && (!found || ((op == OP_BEST_FIT) && (len < pick_len)));
  assign mlen = lst[kidx] - fst[kidx];
  assign free_hit = (state == S_CHECK) && (op == OP_FREE) && any_match;

  always_comb begin
    if (state == S_COMPACT) begin
      new_first = cursor;
      new_last  = cursor + mlen;
    end else begin
      new_first = pick_lo;
      new_last  = pick_lo + size_a;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      ctl[i].key = id;
      ctl[i].cmd = CMD_HOLD;
      if (cfg_fire) begin
        ctl[i].cmd = CMD_CLEAR;
      end else if (state == S_INSERT) begin
        if (IW'(i) == pick) ctl[i].cmd = CMD_LOAD;
        else if (IW'(i) > pick) ctl[i].cmd = CMD_FROM_LO;
      end else if (free_hit) begin
        if (CW'(i) == last_used) ctl[i].cmd = CMD_KILL;
        else if (IW'(i) >= at && CW'(i) < last_used) ctl[i].cmd = CMD_FROM_HI;
      end else if (state == S_COMPACT && k < count && CW'(i) == k) begin
        ctl[i].cmd = CMD_MOVE;
      end
    end
  end

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    logic             lv, hv;
    logic [15:0]      li, hid;
    logic [A-1:0]     lf, ll, hf, hl;
    if (g == 0) begin : g_lo0
      assign lv = 1'b0;
      assign li = '0;
      assign lf = '0;
      assign ll = '0;
    end else begin : g_lo
      assign lv = v[g-1];
      assign li = idt[g-1];
      assign lf = fst[g-1];
      assign ll = lst[g-1];
    end
    if (g == MAX_REGIONS - 1) begin : g_hiN
      assign hv  = 1'b0;
      assign hid = '0;
      assign hf  = '0;
      assign hl  = '0;
    end else begin : g_hi
      assign hv  = v[g+1];
      assign hid = idt[g+1];
      assign hf  = fst[g+1];
      assign hl  = lst[g+1];
    end
    cba_cell #(.ADDR_BITS(A)) u_cell (
      .clk(clk), .rst(rst), .ctrl(ctl[g]),
      .lo_valid(lv), .lo_ident(li), .lo_first(lf), .lo_last(ll),
      .hi_valid(hv), .hi_ident(hid), .hi_first(hf), .hi_last(hl),
      .new_ident(id), .new_first(new_first), .new_last(new_last),
      .valid(v[g]), .ident(idt[g]), .first(fst[g]), .last(lst[g]),
      .match(mt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total_size <= toa(16'hFFFF);
      space      <= toa(16'hFFFF);
      count      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (cfg_fire) begin
        total_size <= toa(cfg_data);
        space      <= toa(cfg_data);
        count      <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (req_valid) begin
              op         <= req.operation;
              id         <= req.region_id;
              size       <= req.region_size;
              res_start  <= '0;
              res_end    <= '0;
              res_status <= ST_OK;
              k          <= '0;
              prev_last  <= '0;
              cursor     <= '0;
              found      <= 1'b0;
              state      <= S_CHECK;
            end
          end
          S_CHECK: begin
            if (op == OP_COMPACT) begin
              state <= S_COMPACT;
            end else if (op == OP_FREE) begin
              state <= S_DONE;
              if (any_match) begin
                res_start <= fst[at];
                res_end   <= lst[at];
                space     <= space + (lst[at] - fst[at]);
                count     <= count - CW'(1);
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end else if (32'(size) > 32'(space)) begin
              res_status <= ST_EXCEEDS;
              state      <= S_DONE;
            end else if (any_match) begin
              res_status <= ST_DUPLICATE;
              state      <= S_DONE;
            end else if (count == CW'(MAX_REGIONS)) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
          S_SCAN: begin
            prev_last <= lst[kidx];
            k         <= k + CW'(1);
            if (take) begin
              found    <= 1'b1;
              pick     <= kidx;
              pick_lo  <= prev_last;
              pick_len <= len;
            end
            if (take && op == OP_FIRST_FIT) begin
              state <= S_INSERT;
            end else if (k == count) begin
              if (take || found) begin
                state <= S_INSERT;
              end else begin
                res_status <= ST_NO_HOLE;
                state      <= S_DONE;
              end
            end
          end
          S_INSERT: begin
            res_start <= new_first;
            res_end   <= new_last;
            count     <= count + CW'(1);
            space     <= space - size_a;
            state     <= S_DONE;
          end
          S_COMPACT: begin
            if (k == count) begin
              state <= S_DONE;
            end else begin
              cursor <= cursor + mlen;
              k      <= k + CW'(1);
            end
          end
          S_DONE: begin
            if (!rsp_valid || rsp_ready) begin
              rsp.status        <= res_status;
              rsp.region_start  <= to16(res_start);
              rsp.region_end    <= to16(res_end);
              rsp.free_space    <= to16(space);
              state             <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REGIONS)) else $error("region count overflow");
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(vbits) == 32'(count)) else $error("valid bits disagree with count");
  a_space_range: assert property (@(posedge clk) disable iff (rst)
    space <= total_size) else $error("free space above memory size");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.region_start == 16'd0 &&
    rsp.region_end == 16'd0) else $error("rejected transaction carries a region");
`endif

endmodule

FILE: tb/contiguous_block_allocator_test.sv
// Testbench for contiguous_block_allocator: random and directed requests
// checked against a region table model kept in a scoreboard class.
// Depends on cba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module contiguous_block_allocator_test;
  import cba_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  class region_scoreboard;
    bit [15:0] total_size;
    bit [15:0] ids[SLOTS];
    bit [15:0] firsts[SLOTS];
    bit [15:0] lasts[SLOTS];
    int count;
    bit [15:0] space;
    rsp_item_t pending[$];
    int errors;

    function void clear(bit [15:0] size);
      total_size = size;
      count = 0;
      space = size;
    endfunction

    function bit [15:0] lo_of(int k);
      return (k == 0) ? 16'd0 : lasts[k - 1];
    endfunction

    function bit [15:0] len_of(int k);
      bit [15:0] lo;
      bit [15:0] hi;
      lo = lo_of(k);
      hi = (k < count) ? firsts[k] : total_size;
      return (hi > lo) ? hi - lo : 16'd0;
    endfunction

    function int find(bit [15:0] id);
      for (int k = 0; k < count; k++) if (ids[k] == id) return k;
      return -1;
    endfunction

    function void note_request(req_item_t r);
      rsp_item_t e;
      int pick;
      bit [15:0] pick_len;
      bit [15:0] cursor;
      bit [15:0] len;
      int at;
      e = '0;
      e.status = ST_OK;
      if (r.operation == OP_FIRST_FIT || r.operation == OP_BEST_FIT) begin
        pick = -1;
        pick_len = '0;
        if (r.region_size > space) e.status = ST_EXCEEDS;
        else if (find(r.region_id) >= 0) e.status = ST_DUPLICATE;
        else if (count >= SLOTS) e.status = ST_FULL;
        else begin
          for (int k = 0; k <= count; k++) begin
            len = len_of(k);
            if (pick < 0 && r.region_size <= len) begin
              pick = k;
              pick_len = len;
              if (r.operation == OP_FIRST_FIT) break;
            end else if (pick >= 0 && r.region_size <= len && len < pick_len) begin
              pick = k;
              pick_len = len;
            end
          end
          if (pick < 0) e.status = ST_NO_HOLE;
          else begin
            e.region_start = lo_of(pick);
            e.region_end = e.region_start + r.region_size;
            for (int k = count; k > pick; k--) begin
              ids[k] = ids[k - 1];
              firsts[k] = firsts[k - 1];
              lasts[k] = lasts[k - 1];
            end
            ids[pick] = r.region_id;
            firsts[pick] = e.region_start;
            lasts[pick] = e.region_end;
            count++;
            space -= r.region_size;
          end
        end
      end else if (r.operation == OP_FREE) begin
        at = find(r.region_id);
        if (at < 0) e.status = ST_NOT_FOUND;
        else begin
          e.region_start = firsts[at];
          e.region_end = lasts[at];
          space += lasts[at] - firsts[at];
          for (int k = at; k + 1 < count; k++) begin
            ids[k] = ids[k + 1];
            firsts[k] = firsts[k + 1];
            lasts[k] = lasts[k + 1];
          end
          count--;
        end
      end else begin
        cursor = '0;
        for (int k = 0; k < count; k++) begin
          len = lasts[k] - firsts[k];
          firsts[k] = cursor;
          lasts[k] = cursor + len;
          cursor += len;
        end
      end
      e.free_space = space;
      pending.push_back(e);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(rsp_item_t got);
      rsp_item_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report("status", int'(got.status), int'(e.status));
      if (got.region_start !== e.region_start)
        report("region_start", int'(got.region_start), int'(e.region_start));
      if (got.region_end !== e.region_end)
        report("region_end", int'(got.region_end), int'(e.region_end));
      if (got.free_space !== e.free_space)
        report("free_space", int'(got.free_space), int'(e.free_space));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_item_t rsp;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  region_scoreboard board;
  int cycles = 0;
  int hold_off = 0;
  bit [15:0] recent_ids[$];

  always #1 clk = ~clk;

  contiguous_block_allocator i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial board = new();

  // Receiver: random stalls, plus long hold-off when requested.
  initial begin
    int wait_n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        rsp_ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      wait_n = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        rsp_ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ready <= 1;
      @(posedge clk);
      while (!(rsp_valid && rsp_ready)) @(posedge clk);
      board.check_result(rsp);
    end
  end

  task send_request(bit [1:0] op, bit [15:0] id, bit [15:0] size, bit no_gap);
    req_item_t r;
    int wait_n;
    wait_n = no_gap ? 0 : $urandom_range(0, 11);
    if (wait_n > 0) begin
      req_valid <= 0;
      repeat (wait_n) @(posedge clk);
    end
    r.operation = op;
    r.region_id = id;
    r.region_size = size;
    req <= r;
    req_valid <= 1;
    @(posedge clk);
    while (!(req_valid && req_ready)) @(posedge clk);
    board.note_request(r);
    if (op != OP_FREE && op != OP_COMPACT) recent_ids.push_back(id);
    if (recent_ids.size() > 24) void'(recent_ids.pop_front());
  endtask

  task wait_idle;
    req_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_size(bit [15:0] size);
    cfg_data <= size;
    cfg_valid <= 1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 0;
    board.clear(size);
    recent_ids.delete();
  endtask

  task random_request(bit [15:0] msize, bit no_gap);
    int pick;
    bit [15:0] id;
    bit [15:0] size;
    pick = $urandom_range(0, 99);
    if (recent_ids.size() > 0 && $urandom_range(0, 2) != 0)
      id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    else if ($urandom_range(0, 9) == 0) id = 16'($urandom);
    else id = 16'($urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0: size = 16'($urandom);
      1: size = '0;
      default: size = 16'($urandom_range(0, (msize >> 3) + 1));
    endcase
    if (pick < 35) send_request(OP_FIRST_FIT, id, size, no_gap);
    else if (pick < 65) send_request(OP_BEST_FIT, id, size, no_gap);
    else if (pick < 92) send_request(OP_FREE, id, size, no_gap);
    else send_request(OP_COMPACT, id, size, no_gap);
  endtask

  initial begin
    bit [15:0] sizes[5];
    board.clear(16'hFFFF);
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, each status but ST_NO_HOLE, zero size, compact.
    send_request(OP_FIRST_FIT, 16'hFFFF, 16'hFFFF, 0);
    send_request(OP_FREE, 16'hFFFF, 16'h0000, 0);
    send_request(OP_FIRST_FIT, 16'h0001, 16'h0000, 0);
    send_request(OP_BEST_FIT, 16'h0001, 16'h0010, 0);
    send_request(OP_FREE, 16'h1234, 16'hFFFF, 0);
    wait_idle();
    write_size(16'd100);
    send_request(OP_FIRST_FIT, 16'd1, 16'd101, 0);
    send_request(OP_FIRST_FIT, 16'd1, 16'd30, 0);
    send_request(OP_FIRST_FIT, 16'd2, 16'd10, 0);
    send_request(OP_FIRST_FIT, 16'd3, 16'd40, 0);
    send_request(OP_FREE, 16'd1, 16'd0, 0);
    send_request(OP_BEST_FIT, 16'd4, 16'd5, 0);
    send_request(OP_FIRST_FIT, 16'd5, 16'd60, 0);
    send_request(OP_COMPACT, 16'd0, 16'd0, 0);
    send_request(OP_FIRST_FIT, 16'd5, 16'd45, 0);
    for (int k = 0; k < 5; k++) send_request(OP_BEST_FIT, 16'(10 + k), 16'd0, 0);
    wait_idle();
    write_size(16'd0);
    for (int k = 0; k < 18; k++) send_request(OP_FIRST_FIT, 16'(k), 16'd0, 1);
    wait_idle();
    // Random phases over several sizes.
    sizes = '{16'd64, 16'hFFFF, 16'd1, 16'd1000, 16'd0};
    for (int p = 0; p < 5; p++) begin
      write_size(sizes[p]);
      for (int i = 0; i < 300; i++) begin
        if (p == 1 && i == 100) hold_off = 400;
        random_request(sizes[p], p == 1 && i >= 100 && i < 140);
      end
      wait_idle();
    end
    wait_idle();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: sim.f
rtl/cba_pkg.sv
rtl/cba_cell.sv
rtl/contiguous_block_allocator.sv
tb/contiguous_block_allocator_test.sv
